/* sv/tsof_pkg.sv */
// Shared constants and types for the touch sample outlier filter.
`default_nettype none

package tsof_pkg;

  // Number of converter samples carried by one item.
  localparam int NUM_SAMPLES = 5;

  // Sorted window width and weighting of the average (5*a + 6*b + 5*c) >> 4.
  localparam int WINDOW_LEN   = 3;
  localparam int WEIGHT_OUTER = 5;
  localparam int AVG_SHIFT    = 4;

  // Extra bits the weighted sum needs above the sample width.
  localparam int SUM_EXTRA    = 5;

  // Which window of three adjacent sorted samples was chosen.
  typedef enum logic [1:0] {
    WIN_LOW  = 2'd0,
    WIN_MID  = 2'd1,
    WIN_HIGH = 2'd2
  } win_sel_t;

endpackage

`default_nettype wire

/* sv/tsof_if.sv */
// Valid/ready channel interfaces for sample items and result items.
`default_nettype none

interface tsof_in_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_0;
  logic [SAMPLE_BITS-1:0] sample_1;
  logic [SAMPLE_BITS-1:0] sample_2;
  logic [SAMPLE_BITS-1:0] sample_3;
  logic [SAMPLE_BITS-1:0] sample_4;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
    output ready
  );
endinterface

interface tsof_out_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered_value;
  logic [SAMPLE_BITS-1:0] spread;

  modport source (
    output valid, filtered_value, spread,
    input  ready
  );
  modport sink (
    input  valid, filtered_value, spread,
    output ready
  );
endinterface

`default_nettype wire

/* sv/tsof_sort.sv */
// Nine-comparator sorting network for five samples, ascending.
`default_nettype none

module tsof_sort
  import tsof_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic [SAMPLE_BITS-1:0] unsorted [NUM_SAMPLES],
  output logic      [SAMPLE_BITS-1:0] sorted   [NUM_SAMPLES]
);

  logic [SAMPLE_BITS-1:0] l0 [NUM_SAMPLES];
  logic [SAMPLE_BITS-1:0] l1 [NUM_SAMPLES];
  logic [SAMPLE_BITS-1:0] l2 [NUM_SAMPLES];
  logic [SAMPLE_BITS-1:0] l3 [NUM_SAMPLES];
  logic [SAMPLE_BITS-1:0] l4 [NUM_SAMPLES];
  logic [SAMPLE_BITS-1:0] l5 [NUM_SAMPLES];
  logic [SAMPLE_BITS-1:0] l6 [NUM_SAMPLES];
  logic [SAMPLE_BITS-1:0] l7 [NUM_SAMPLES];
  logic [SAMPLE_BITS-1:0] l8 [NUM_SAMPLES];

  // Each step orders one pair; the others pass through unchanged.
  always_comb begin
    l0 = unsorted;
    if (l0[0] > l0[3]) begin l0[0] = unsorted[3]; l0[3] = unsorted[0]; end
    l1 = l0;
    if (l1[1] > l1[4]) begin l1[1] = l0[4]; l1[4] = l0[1]; end
    l2 = l1;
    if (l2[0] > l2[2]) begin l2[0] = l1[2]; l2[2] = l1[0]; end
    l3 = l2;
    if (l3[1] > l3[3]) begin l3[1] = l2[3]; l3[3] = l2[1]; end
    l4 = l3;
    if (l4[0] > l4[1]) begin l4[0] = l3[1]; l4[1] = l3[0]; end
    l5 = l4;
    if (l5[2] > l5[4]) begin l5[2] = l4[4]; l5[4] = l4[2]; end
    l6 = l5;
    if (l6[1] > l6[2]) begin l6[1] = l5[2]; l6[2] = l5[1]; end
    l7 = l6;
    if (l7[3] > l7[4]) begin l7[3] = l6[4]; l7[4] = l6[3]; end
    l8 = l7;
    if (l8[2] > l8[3]) begin l8[2] = l7[3]; l8[3] = l7[2]; end
  end

  assign sorted = l8;

endmodule

`default_nettype wire

/* sv/tsof_window.sv */
// Picks the tightest window of three sorted samples and averages it.
`default_nettype none

module tsof_window
  import tsof_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic [SAMPLE_BITS-1:0] sorted [NUM_SAMPLES],
  output logic      [SAMPLE_BITS-1:0] filtered_value,
  output logic      [SAMPLE_BITS-1:0] spread
);

  localparam int SUM_BITS = SAMPLE_BITS + SUM_EXTRA;

  logic [SAMPLE_BITS-1:0] d_low;
  logic [SAMPLE_BITS-1:0] d_mid;
  logic [SAMPLE_BITS-1:0] d_high;
  logic [SAMPLE_BITS-1:0] d_best;
  win_sel_t               win;
  logic [SAMPLE_BITS-1:0] a;
  logic [SAMPLE_BITS-1:0] b;
  logic [SAMPLE_BITS-1:0] c;
  logic [SUM_BITS-1:0]    sum3;
  logic [SUM_BITS-1:0]    wsum;
  logic [SAMPLE_BITS-1:0] avg;

  // Spreads of the three windows; sorted order keeps them non-negative.
  assign d_mid  = sorted[3] - sorted[1];
  assign d_low  = sorted[2] - sorted[0];
  assign d_high = sorted[4] - sorted[2];

  // Middle window first; a later window wins only on a strictly smaller spread.
  always_comb begin
    win    = WIN_MID;
    d_best = d_mid;
    if (d_low < d_best) begin
      win    = WIN_LOW;
      d_best = d_low;
    end
    if (d_high < d_best) begin
      win    = WIN_HIGH;
      d_best = d_high;
    end
  end

  // Window members.
  always_comb begin
    unique case (win)
      WIN_LOW: begin
        a = sorted[0]; b = sorted[1]; c = sorted[2];
      end
      WIN_HIGH: begin
        a = sorted[2]; b = sorted[3]; c = sorted[4];
      end
      default: begin
        a = sorted[1]; b = sorted[2]; c = sorted[3];
      end
    endcase
  end

  // Weighted sum 5*(a+b+c) + b, then divide by sixteen.
  assign sum3 = SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c);
  assign wsum = SUM_BITS'(sum3 * SUM_BITS'(WEIGHT_OUTER)) + SUM_BITS'(b);
  assign avg  = SAMPLE_BITS'(wsum >> AVG_SHIFT);

  // A zero average is reported as one.
  assign filtered_value = (avg == '0) ? SAMPLE_BITS'(1) : avg;
  assign spread         = d_best;

endmodule

`default_nettype wire

/* sv/touch_sample_outlier_filter_core.sv */
// Top level of the five-sample touch outlier filter.
//
//   channel     dir  payload
//   sample_in   in   sample_0 .. sample_4, SAMPLE_BITS each
//   result_out  out  filtered_value, spread, SAMPLE_BITS each
//
// Three register stages: input, sorted samples, result. One item is taken
// every cycle unless a stalled result has filled the stages. An accepted item
// is registered in the sorted and then the result stage before it is offered.
// Every stage has its own valid bit, so a stalled result only holds the stages
// behind it once they are full. Reset clears the valid bits only.
`default_nettype none

module touch_sample_outlier_filter_core
  import tsof_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tsof_in_if.sink       sample_in,
  tsof_out_if.source    result_out
);

  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_smp    [NUM_SAMPLES];
  logic                   srt_valid;
  logic [SAMPLE_BITS-1:0] srt_smp   [NUM_SAMPLES];
  logic                   res_valid;
  logic [SAMPLE_BITS-1:0] res_value;
  logic [SAMPLE_BITS-1:0] res_spread;

  logic [SAMPLE_BITS-1:0] sorted    [NUM_SAMPLES];
  logic [SAMPLE_BITS-1:0] win_value;
  logic [SAMPLE_BITS-1:0] win_spread;
  logic                   res_ready;
  logic                   srt_ready;
  logic                   in_ready;

  // Each stage loads when it is empty or its item moves on.
  assign res_ready = !res_valid || result_out.ready;
  assign srt_ready = !srt_valid || res_ready;
  assign in_ready  = !in_valid  || srt_ready;
  assign sample_in.ready = in_ready;

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= sample_in.valid;
    end
    if (in_ready && sample_in.valid) begin
      in_smp[0] <= sample_in.sample_0;
      in_smp[1] <= sample_in.sample_1;
      in_smp[2] <= sample_in.sample_2;
      in_smp[3] <= sample_in.sample_3;
      in_smp[4] <= sample_in.sample_4;
    end
  end

  tsof_sort #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_sort (
    .unsorted(in_smp),
    .sorted  (sorted)
  );

  // Sorted stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      srt_valid <= 1'b0;
    end else if (srt_ready) begin
      srt_valid <= in_valid;
    end
    if (srt_ready && in_valid) begin
      srt_smp <= sorted;
    end
  end

  tsof_window #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .sorted        (srt_smp),
    .filtered_value(win_value),
    .spread        (win_spread)
  );

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= srt_valid;
    end
    if (res_ready && srt_valid) begin
      res_value  <= win_value;
      res_spread <= win_spread;
    end
  end

  assign result_out.valid          = res_valid;
  assign result_out.filtered_value = res_value;
  assign result_out.spread         = res_spread;

endmodule

`default_nettype wire
